// File: hw/rtl/gaa_pkg.sv
`default_nettype none
package gaa_pkg;

  localparam int POS_W  = 32;
  localparam int MASS_W = 32;
  localparam int G_W    = 32;
  localparam int ACC_W  = 48;
  localparam int DIFF_W = POS_W + 1;
  localparam int D2_W   = 2 * DIFF_W;
  localparam int ROOT_W = 49;
  localparam int SQX_W  = 2 * ROOT_W;
  localparam int SQRT_EXTRA = 16;
  localparam int GM_W   = G_W + MASS_W;

  localparam logic [G_W-1:0] G_RESET = 32'h0001_0000;

  localparam logic signed [ACC_W+1:0] SAT_MAX = 50'sd140737488355327;
  localparam logic signed [ACC_W+1:0] SAT_MIN = -50'sd140737488355328;

  // busy / done status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // saturating add of a sign-magnitude contribution
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] sum,
    input logic [ACC_W-1:0]        mag,
    input logic                    neg
  );
    logic signed [ACC_W+1:0] c;
    logic signed [ACC_W+1:0] t;
    c = $signed({2'b00, mag});
    if (neg) begin
      c = -c;
    end
    t = {{2{sum[ACC_W-1]}}, sum} + c;
    if (t > SAT_MAX) begin
      t = SAT_MAX;
    end else if (t < SAT_MIN) begin
      t = SAT_MIN;
    end
    return t[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gaa_mul.sv
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle, stops when b runs out
module gaa_mul #(
  parameter int A_W = 66,
  parameter int B_W = 49
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output gaa_pkg::unit_stat_t       stat,
  output logic [A_W+B_W-1:0]        prod
);
  import gaa_pkg::*;

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = {{B_W{1'b0}}, a};
      b_nxt    = b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule
`default_nettype wire

// File: hw/rtl/gaa_sqrt.sv
`default_nettype none
// digit-by-digit integer square root, one root bit per cycle
module gaa_sqrt #(
  parameter int R_W = 49
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [2*R_W-1:0] x,
  output gaa_pkg::unit_stat_t   stat,
  output logic [R_W-1:0]        root
);
  import gaa_pkg::*;

  localparam int X_W   = 2 * R_W;
  localparam int REM_W = R_W + 3;
  localparam int CNT_W = $clog2(R_W + 1);

  logic [X_W-1:0]   x_r, x_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, t, trial;
  logic [R_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  assign t     = {rem_r[REM_W-3:0], x_r[X_W-1:X_W-2]};
  assign trial = {1'b0, root_r, 2'b01};

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(R_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (t >= trial) begin
        rem_nxt  = t - trial;
        root_nxt = {root_r[R_W-2:0], 1'b1};
      end else begin
        rem_nxt  = t;
        root_nxt = {root_r[R_W-2:0], 1'b0};
      end
      x_nxt   = x_r << 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule
`default_nettype wire

// File: hw/rtl/gaa_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient clamped to 2^(ACC_W-1)
module gaa_div #(
  parameter int NUM_W = 137,
  parameter int DEN_W = 115
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [NUM_W-1:0]        num,
  input  wire logic [DEN_W-1:0]        den,
  output gaa_pkg::unit_stat_t          stat,
  output logic [gaa_pkg::ACC_W-1:0]    quo
);
  import gaa_pkg::*;

  localparam int L_W   = ACC_W - 1;
  localparam int R_W   = DEN_W + 1;
  localparam int CNT_W = $clog2(L_W + 1);

  logic [R_W-1:0]   rem_r, rem_nxt, rem0, t, den_ext;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [L_W-1:0]   bits_r, bits_nxt;
  logic [ACC_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;

  assign rem0    = R_W'(num[NUM_W-1:L_W]);
  assign t       = {rem_r[R_W-2:0], bits_r[L_W-1]};
  assign den_ext = {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bits_nxt = bits_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      den_nxt  = den;
      rem_nxt  = rem0;
      bits_nxt = num[L_W-1:0];
      cnt_nxt  = CNT_W'(L_W);
      if (rem0 >= {1'b0, den}) begin
        // quotient at or past full scale
        q_nxt    = {1'b1, {L_W{1'b0}}};
        done_nxt = 1'b1;
      end else begin
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (t >= den_ext) begin
        rem_nxt = t - den_ext;
        q_nxt   = {q_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = t;
        q_nxt   = {q_r[ACC_W-2:0], 1'b0};
      end
      bits_nxt = bits_r << 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    bits_r <= bits_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule
`default_nettype wire

// File: hw/rtl/gravity_acceleration_accumulator_core.sv
// Per item: a self item goes straight to ST_FIN. For a coincident source both squares see a zero
// multiplier. A full source runs two 33-bit squares, a 49-step root,
// serial multiplies over 32, 49 and twice 33 bits, and two 47-step divides.
// Multiplies end early when the multiplier operand runs out of ones; a clamped divide skips the bit loop.
// Throughput: one word at a time; in_stall is high from accept until the sequencer is idle.
// Reset (sync, active low): sums clear, g_r returns to 1.0, output word dropped.
`default_nettype none
module gravity_acceleration_accumulator_core #(
  parameter int POS_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config
  input  wire logic                                cfg_we,
  input  wire logic [gaa_pkg::G_W-1:0]             cfg_wdata,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [gaa_pkg::POS_W-1:0]    in_target_x,
  input  wire logic signed [gaa_pkg::POS_W-1:0]    in_target_y,
  input  wire logic signed [gaa_pkg::POS_W-1:0]    in_source_x,
  input  wire logic signed [gaa_pkg::POS_W-1:0]    in_source_y,
  input  wire logic [gaa_pkg::MASS_W-1:0]          in_source_mass,
  input  wire logic                                in_is_self,
  input  wire logic                                in_last,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [gaa_pkg::ACC_W-1:0]         out_accel_x,
  output logic signed [gaa_pkg::ACC_W-1:0]         out_accel_y
);
  import gaa_pkg::*;

  // numerator scale: 2P-8 for the units, plus the extra root fraction bits
  localparam int SH    = 2 * POS_FRAC_BITS - 8 + SQRT_EXTRA;
  localparam int NP_W  = GM_W + DIFF_W;
  localparam int NUM_W = NP_W + SH;
  localparam int DEN_W = D2_W + ROOT_W;
  localparam int MA_W  = D2_W;
  localparam int MB_W  = ROOT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_CHK, ST_ROOT, ST_GM, ST_DEN,
    ST_NUM_X, ST_DIV_X, ST_NUM_Y, ST_DIV_Y, ST_FIN
  } st_t;

  st_t                       st_r, st_nxt;
  logic                      run_r, run_nxt;
  logic [G_W-1:0]            g_r;
  logic [DIFF_W-1:0]         adx_r, adx_nxt, ady_r, ady_nxt;
  logic                      negx_r, negx_nxt, negy_r, negy_nxt;
  logic [MASS_W-1:0]         mass_r, mass_nxt;
  logic                      last_r, last_nxt;
  logic [D2_W-1:0]           d2_r, d2_nxt;
  logic [GM_W-1:0]           gm_r, gm_nxt;
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic signed [ACC_W-1:0]   sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0]   ax_r, ax_nxt, ay_r, ay_nxt;

  logic signed [DIFF_W-1:0]  dx_c, dy_c;
  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [MA_W+MB_W-1:0]      mul_prod;
  logic [ROOT_W-1:0]         root;
  logic [ACC_W-1:0]          quo;
  unit_stat_t                mul_stat, sqrt_stat, div_stat;
  logic                      mul_start, sqrt_start, div_start;
  logic                      is_mul_st;

  // displacement, source minus target, exact in 33 bits
  assign dx_c = {in_source_x[POS_W-1], in_source_x} - {in_target_x[POS_W-1], in_target_x};
  assign dy_c = {in_source_y[POS_W-1], in_source_y} - {in_target_y[POS_W-1], in_target_y};

  // shared multiplier operand select
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    is_mul_st = 1'b1;
    case (st_r)
      ST_SQ_X: begin
        mul_a = MA_W'(adx_r);
        mul_b = MB_W'(adx_r);
      end
      ST_SQ_Y: begin
        mul_a = MA_W'(ady_r);
        mul_b = MB_W'(ady_r);
      end
      ST_GM: begin
        mul_a = MA_W'(g_r);
        mul_b = MB_W'(mass_r);
      end
      ST_DEN: begin
        mul_a = d2_r;
        mul_b = root;
      end
      ST_NUM_X: begin
        mul_a = MA_W'(gm_r);
        mul_b = MB_W'(adx_r);
      end
      ST_NUM_Y: begin
        mul_a = MA_W'(gm_r);
        mul_b = MB_W'(ady_r);
      end
      default: is_mul_st = 1'b0;
    endcase
  end

  // each unit is kicked on the first cycle of its state
  assign mul_start  = is_mul_st && !run_r;
  assign sqrt_start = (st_r == ST_ROOT) && !run_r;
  assign div_start  = ((st_r == ST_DIV_X) || (st_r == ST_DIV_Y)) && !run_r;

  gaa_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  // root of D2 shifted up 32 bits, so the root has 16 extra fraction bits
  gaa_sqrt #(.R_W(ROOT_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     ({d2_r, {(SQX_W-D2_W){1'b0}}}),
    .stat  (sqrt_stat),
    .root  (root)
  );

  // numerator is G*m*|dc| held in the multiplier, scaled up
  gaa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({mul_prod[NP_W-1:0], {SH{1'b0}}}),
    .den   (den_r),
    .stat  (div_stat),
    .quo   (quo)
  );

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    run_nxt       = run_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    mass_nxt      = mass_r;
    last_nxt      = last_r;
    d2_nxt        = d2_r;
    gm_nxt        = gm_r;
    den_nxt       = den_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          adx_nxt  = dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
          ady_nxt  = dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
          negx_nxt = dx_c[DIFF_W-1];
          negy_nxt = dy_c[DIFF_W-1];
          mass_nxt = in_source_mass;
          last_nxt = in_last;
          run_nxt  = 1'b0;
          st_nxt   = in_is_self ? ST_FIN : ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          d2_nxt  = mul_prod[D2_W-1:0];
          run_nxt = 1'b0;
          st_nxt  = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          d2_nxt  = d2_r + mul_prod[D2_W-1:0];
          run_nxt = 1'b0;
          st_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        // coincident source adds nothing
        st_nxt = (d2_r == '0) ? ST_FIN : ST_ROOT;
      end
      ST_ROOT: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (sqrt_stat.done) begin
          run_nxt = 1'b0;
          st_nxt  = ST_GM;
        end
      end
      ST_GM: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          gm_nxt  = mul_prod[GM_W-1:0];
          run_nxt = 1'b0;
          st_nxt  = ST_DEN;
        end
      end
      ST_DEN: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          den_nxt = mul_prod[DEN_W-1:0];
          run_nxt = 1'b0;
          st_nxt  = ST_NUM_X;
        end
      end
      ST_NUM_X: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          run_nxt = 1'b0;
          st_nxt  = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (div_stat.done) begin
          sum_x_nxt = sat_add(sum_x_r, quo, negx_r);
          run_nxt   = 1'b0;
          st_nxt    = ST_NUM_Y;
        end
      end
      ST_NUM_Y: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (mul_stat.done) begin
          run_nxt = 1'b0;
          st_nxt  = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (!run_r) begin
          run_nxt = 1'b1;
        end else if (div_stat.done) begin
          sum_y_nxt = sat_add(sum_y_r, quo, negy_r);
          run_nxt   = 1'b0;
          st_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          st_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          // output slot free: emit the word and clear the sums
          ax_nxt        = sum_x_r;
          ay_nxt        = sum_y_r;
          out_valid_nxt = 1'b1;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      run_r       <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
      g_r         <= G_RESET;
    end else begin
      st_r        <= st_nxt;
      run_r       <= run_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        g_r <= cfg_wdata;
      end
    end
    adx_r  <= adx_nxt;
    ady_r  <= ady_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    mass_r <= mass_nxt;
    last_r <= last_nxt;
    d2_r   <= d2_nxt;
    gm_r   <= gm_nxt;
    den_r  <= den_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
  end

  assign in_stall    = (st_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_accel_x = ax_r;
  assign out_accel_y = ay_r;

  // sums are clear right after a word is emitted
  a_sum_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && last_r && (!out_valid_r || !out_stall))
      |=> (sum_x_r == '0 && sum_y_r == '0 && out_valid_r))
    else $error("sums not cleared on emit");

  // a unit only reports done while the sequencer waits on it
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> run_r)
    else $error("multiplier done with no pending request");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (run_r && (st_r == ST_DIV_X || st_r == ST_DIV_Y)))
    else $error("divider done outside a divide state");

  // a word only appears for an item flagged last
  a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_r))
    else $error("output word without last");

endmodule
`default_nettype wire

// File: test/gravity_acceleration_accumulator_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module gravity_acceleration_accumulator_core_tb;
  import gaa_pkg::*;

  localparam int FRAC = 16;
  // extra numerator shift: two position fraction scalings, Q24.24 out, sqrt extra bits
  localparam int NUM_SHIFT = 2 * FRAC - 8 + SQRT_EXTRA;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
  } accel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [G_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] in_target_x = '0;
  logic signed [POS_W-1:0] in_target_y = '0;
  logic signed [POS_W-1:0] in_source_x = '0;
  logic signed [POS_W-1:0] in_source_y = '0;
  logic [MASS_W-1:0] in_source_mass = '0;
  logic in_is_self = 1'b0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ACC_W-1:0] out_accel_x;
  logic signed [ACC_W-1:0] out_accel_y;

  // predictor state
  logic [G_W-1:0] g_model = G_RESET;
  logic signed [ACC_W-1:0] sum_x_model = '0;
  logic signed [ACC_W-1:0] sum_y_model = '0;
  accel_t accel_q[$];

  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sat_hits = 0;

  gravity_acceleration_accumulator_core #(.POS_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_source_x(in_source_x), .in_source_y(in_source_y),
    .in_source_mass(in_source_mass), .in_is_self(in_is_self), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_accel_x(out_accel_x), .out_accel_y(out_accel_y)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // floor(sqrt(x)), x < 2^98, result fits 49 bits
  function automatic logic [63:0] dist_root(input logic [255:0] x);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (256'(cand) * 256'(cand) <= x) begin
        res = cand;
      end
    end
    return res;
  endfunction

  // one axis of G*m*r/|r|^3, magnitude clamped to 2^47, returned signed 50 bits
  function automatic logic signed [ACC_W+1:0] axis_pull(input logic [63:0] gm,
                                                        input logic signed [DIFF_W-1:0] dc,
                                                        input logic [255:0] den);
    logic [DIFF_W-1:0] mag_dc;
    logic [255:0] num;
    logic [255:0] quo;
    logic signed [ACC_W+1:0] mag;
    mag_dc = dc[DIFF_W-1] ? -dc : dc;
    num = (256'(gm) * 256'(mag_dc)) << NUM_SHIFT;
    quo = num / den;
    if (quo >= (256'd1 << 47)) begin
      mag = 50'sd140737488355328;
    end else begin
      mag = $signed({2'b00, quo[47:0]});
    end
    return dc[DIFF_W-1] ? -mag : mag;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_sum(input logic signed [ACC_W-1:0] s,
                                                       input logic signed [ACC_W+1:0] c);
    logic signed [ACC_W+1:0] t;
    t = $signed({{2{s[ACC_W-1]}}, s}) + c;
    if (t > SAT_MAX) begin
      t = SAT_MAX;
      sat_hits++;
    end else if (t < SAT_MIN) begin
      t = SAT_MIN;
      sat_hits++;
    end
    return t[ACC_W-1:0];
  endfunction

  // fold one accepted word into the running sums; on last, queue the expected result
  task automatic predict_accel(input logic signed [POS_W-1:0] tx, input logic signed [POS_W-1:0] ty,
                               input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
                               input logic [MASS_W-1:0] m, input logic self, input logic last);
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] ux;
    logic [DIFF_W-1:0] uy;
    logic [255:0] d2;
    logic [255:0] den;
    logic [63:0] gm;
    accel_t r;
    if (!self) begin
      dx = $signed({sx[POS_W-1], sx}) - $signed({tx[POS_W-1], tx});
      dy = $signed({sy[POS_W-1], sy}) - $signed({ty[POS_W-1], ty});
      ux = dx[DIFF_W-1] ? -dx : dx;
      uy = dy[DIFF_W-1] ? -dy : dy;
      d2 = 256'(ux) * 256'(ux) + 256'(uy) * 256'(uy);
      // coincident source adds nothing
      if (d2 != 0) begin
        den = d2 * 256'(dist_root(d2 << (2 * SQRT_EXTRA)));
        gm = 64'(g_model) * 64'(m);
        sum_x_model = clamp_sum(sum_x_model, axis_pull(gm, dx, den));
        sum_y_model = clamp_sum(sum_y_model, axis_pull(gm, dy, den));
      end
    end
    if (last) begin
      r.ax = sum_x_model;
      r.ay = sum_y_model;
      accel_q.push_back(r);
      sum_x_model = '0;
      sum_y_model = '0;
    end
  endtask

  // one word on the input channel, with an optional random gap in front
  task automatic send_word(input logic signed [POS_W-1:0] tx, input logic signed [POS_W-1:0] ty,
                           input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
                           input logic [MASS_W-1:0] m, input logic self, input logic last);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= tx;
    in_target_y <= ty;
    in_source_x <= sx;
    in_source_y <= sy;
    in_source_mass <= m;
    in_is_self <= self;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    predict_accel(tx, ty, sx, sy, m, self, last);
    words_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // wait for the block to drain, then write G
  task automatic write_g(input logic [G_W-1:0] v);
    drop_valid();
    wait (accel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    g_model = v;
  endtask

  // result side: random stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (sink_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    accel_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (accel_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = accel_q.pop_front();
        if (out_accel_x !== e.ax) begin
          report($sformatf("accel_x got %h exp %h", out_accel_x, e.ax));
        end
        if (out_accel_y !== e.ay) begin
          report($sformatf("accel_y got %h exp %h", out_accel_y, e.ay));
        end
      end
    end
  end

  // corners of the fields at reset G
  task automatic test_extremes();
    // widest separation, heaviest mass
    send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'hffff_ffff, 1'b0, 1'b1);
    send_word(32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 32'sh0, 32'hffff_ffff, 1'b0, 1'b1);
    // single LSB apart with max mass: magnitude clamp then saturation
    send_word(32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'hffff_ffff, 1'b0, 1'b0);
    send_word(32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'hffff_ffff, 1'b0, 1'b1);
    send_word(32'sh0, 32'sh0, -32'sh1, -32'sh1, 32'hffff_ffff, 1'b0, 1'b0);
    send_word(32'sh0, 32'sh0, 32'sh0, -32'sh1, 32'hffff_ffff, 1'b0, 1'b1);
    // zero mass, unit distance
    send_word(32'sh0001_0000, 32'sh0, 32'sh0002_0000, 32'sh0, 32'h0, 1'b0, 1'b1);
    // unit mass at unit distance on each axis
    send_word(32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'h0001_0000, 1'b0, 1'b0);
    send_word(32'sh0, 32'sh0, 32'sh0, -32'sh0001_0000, 32'h0001_0000, 1'b0, 1'b1);
  endtask

  // self and coincident sources add nothing; last still emits
  task automatic test_self_and_coincident();
    send_word(32'sh1234_5678, -32'sh0abc_def0, 32'sh1234_5678, -32'sh0abc_def0,
              32'hffff_ffff, 1'b0, 1'b1);
    send_word(32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0004_0000, 32'h0002_0000, 1'b1, 1'b1);
    send_word(32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0004_0000, 32'h0002_0000, 1'b0, 1'b0);
    send_word(32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0004_0000, 32'hffff_ffff, 1'b1, 1'b0);
    send_word(32'sh5, 32'sh5, 32'sh5, 32'sh5, 32'h1, 1'b0, 1'b1);
    // pause until the block has nothing outstanding
    drop_valid();
    wait (accel_q.size() == 0);
  endtask

  task automatic test_g_settings();
    write_g(32'h0);
    send_word(32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'hffff_ffff, 1'b0, 1'b1);
    write_g(32'hffff_ffff);
    send_word(32'sh0, 32'sh0, 32'sh0100_0000, -32'sh0100_0000, 32'hffff_ffff, 1'b0, 1'b1);
    send_word(32'sh0, 32'sh0, 32'sh7fff_ffff, 32'sh1, 32'h1, 1'b0, 1'b1);
    write_g(32'h1);
    send_word(32'sh0, 32'sh0, 32'sh10, 32'sh10, 32'h1, 1'b0, 1'b1);
  endtask

  // mostly well-formed target runs with random content, some noise words
  task automatic random_runs(input int n_words);
    int sent;
    int len;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    logic [MASS_W-1:0] m;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 6) == 0) begin
        send_word($urandom, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        tx = $urandom;
        ty = $urandom;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          ox = $signed($urandom) >>> $urandom_range(0, 31);
          oy = $signed($urandom) >>> $urandom_range(0, 31);
          m = $urandom >> $urandom_range(0, 31);
          send_word(tx, ty, tx + ox, ty + oy, m, $urandom_range(0, 9) == 0, i == len - 1);
          sent++;
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        write_g($urandom >> $urandom_range(0, 24));
      end
    end
  endtask

  task automatic test_random();
    write_g(G_RESET);
    random_runs(1400);
  endtask

  // final stretch with both sides running flat out
  task automatic test_no_idle();
    write_g($urandom);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    random_runs(300);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_self_and_coincident();
    test_g_settings();
    test_random();
    test_no_idle();
    drop_valid();
    wait (accel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words, %0d acceleration results, %0d saturations",
             words_sent, results_seen, sat_hits);
    $display("G settings included 0, all ones and reset; idle bursts on both sides");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/gaa_pkg.sv
hw/rtl/gaa_mul.sv
hw/rtl/gaa_sqrt.sv
hw/rtl/gaa_div.sv
hw/rtl/gravity_acceleration_accumulator_core.sv
test/gravity_acceleration_accumulator_core_tb.sv
